[rtl/core/tlbr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tlbr_pkg;

	localparam int FRAME_WIDTH  = 1024;
	localparam int FRAME_HEIGHT = 1024;

	localparam logic [15:0] ROW_PITCH_RESET = 16'd4096;

	localparam logic [1:0] KIND_POINT = 2'd0;
	localparam logic [1:0] KIND_LIFT  = 2'd1;
	localparam logic [1:0] KIND_TICK  = 2'd2;

	typedef enum logic [1:0] {
		CMD_POINT,
		CMD_LIFT,
		CMD_TICK,
		CMD_NOP
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t            op;
		logic signed [11:0] pen_x;
		logic signed [11:0] pen_y;
		logic [5:0]         size;
		logic [31:0]        color;
	} cmd_t;

endpackage

`default_nettype wire

[rtl/core/tlbr_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module tlbr_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         kind,
	input  wire logic signed [11:0] pen_x,
	input  wire logic signed [11:0] pen_y,
	input  wire logic [5:0]         brush_size,
	input  wire logic [31:0]        brush_color,
	output logic                    q_valid,
	output tlbr_pkg::cmd_t          q_cmd,
	input  wire logic               q_stall
);
	import tlbr_pkg::*;

	cmd_t       cmd_in;
	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	always_comb begin
		cmd_in.pen_x = pen_x;
		cmd_in.pen_y = pen_y;
		cmd_in.size  = brush_size;
		cmd_in.color = brush_color;
		case (kind)
			KIND_POINT: cmd_in.op = CMD_POINT;
			KIND_LIFT:  cmd_in.op = CMD_LIFT;
			KIND_TICK:  cmd_in.op = CMD_TICK;
			default:    cmd_in.op = CMD_NOP;
		endcase
	end

	assign in_stall = (count_q == 2'd2);
	assign q_valid  = (count_q != 2'd0);
	assign q_cmd    = entry_q[rd_ptr_q];
	assign push     = in_valid && !in_stall;
	assign pop      = q_valid && !q_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cmd_in;
		end
	end

endmodule

`default_nettype wire

[rtl/core/tlbr_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module tlbr_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_valid,
	input  wire tlbr_pkg::cmd_t q_cmd,
	output logic                q_stall,
	input  wire logic [15:0]    row_pitch,
	output logic                out_valid,
	input  wire logic           out_stall,
	output logic                write_valid,
	output logic [9:0]          pixel_x,
	output logic [9:0]          pixel_y,
	output logic [25:0]         byte_address,
	output logic [31:0]         pixel_color,
	output logic                busy_res,
	output logic                rejected
);
	import tlbr_pkg::*;

	// Walk state.
	logic               last_valid_q, last_valid_n;
	logic signed [11:0] last_x_q, last_x_n, last_y_q, last_y_n;
	logic signed [11:0] line_x_q, line_x_n, line_y_q, line_y_n;
	logic signed [11:0] end_x_q, end_x_n, end_y_q, end_y_n;
	logic signed [14:0] err_q, err_n;
	logic signed [12:0] dx_q, dx_n, dy_q, dy_n;
	logic               sx_neg_q, sx_neg_n, sy_neg_q, sy_neg_n;
	logic [5:0]         row_q, row_n, col_q, col_n;
	logic [5:0]         size_q, size_n;
	logic [31:0]        color_q, color_n;
	logic               active_q, active_n;

	// Disc and line arithmetic.
	logic [4:0]         half;
	logic [5:0]         span;
	logic [5:0]         col_inc, row_inc;
	logic signed [6:0]  i_off, j_off;
	logic signed [13:0] i_prod, j_prod;
	logic [10:0]        r2;
	logic [12:0]        lhs;
	logic [11:0]        s_sq;
	logic signed [12:0] xx, yy;
	logic               in_disc, in_frame;
	logic               at_end, step_x, step_y, do_move;
	logic signed [15:0] e2, dx_ext, dy_ext;
	logic signed [11:0] sx0, sy0;
	logic signed [12:0] diff_x, diff_y;
	logic               wv, rej;

	// Pipeline control.
	logic               s1_v_q, s2_v_q;
	logic               s2_ok, s1_ready, take;
	logic               wv_s1, busy_s1, rej_s1;
	logic [11:0]        x_s1, y_s1;
	logic [31:0]        color_s1;
	logic               wv_s2, busy_s2, rej_s2;
	logic [9:0]         x_s2, y_s2;
	logic [25:0]        addr_s2;
	logic [31:0]        color_s2;
	logic [27:0]        addr_full;

	assign half    = size_q[5:1];
	assign span    = {half, 1'b0};
	assign col_inc = col_q + 6'd1;
	assign row_inc = row_q + 6'd1;
	assign i_off   = $signed({1'b0, row_q}) - $signed({2'b00, half});
	assign j_off   = $signed({1'b0, col_q}) - $signed({2'b00, half});
	assign i_prod  = i_off * i_off;
	assign j_prod  = j_off * j_off;
	assign r2      = {1'b0, i_prod[9:0]} + {1'b0, j_prod[9:0]};
	assign lhs     = {r2, 2'b00} + 13'd2;
	assign s_sq    = size_q * size_q;
	assign in_disc = (lhs <= {1'b0, s_sq});
	assign xx      = $signed({line_x_q[11], line_x_q}) + $signed({{6{j_off[6]}}, j_off});
	assign yy      = $signed({line_y_q[11], line_y_q}) + $signed({{6{i_off[6]}}, i_off});
	assign in_frame = !xx[12] && !yy[12]
		&& ({1'b0, xx[11:0]} < 13'(FRAME_WIDTH))
		&& ({1'b0, yy[11:0]} < 13'(FRAME_HEIGHT));

	assign at_end = (line_x_q == end_x_q) && (line_y_q == end_y_q);
	assign e2     = $signed({err_q, 1'b0});
	assign dx_ext = $signed({{3{dx_q[12]}}, dx_q});
	assign dy_ext = $signed({{3{dy_q[12]}}, dy_q});
	assign step_x = (e2 >= dy_ext);
	assign step_y = (e2 <= dx_ext);

	assign sx0    = last_valid_q ? last_x_q : q_cmd.pen_x;
	assign sy0    = last_valid_q ? last_y_q : q_cmd.pen_y;
	assign diff_x = $signed({q_cmd.pen_x[11], q_cmd.pen_x}) - $signed({sx0[11], sx0});
	assign diff_y = $signed({q_cmd.pen_y[11], q_cmd.pen_y}) - $signed({sy0[11], sy0});

	always_comb begin
		last_valid_n = last_valid_q;
		last_x_n     = last_x_q;
		last_y_n     = last_y_q;
		line_x_n     = line_x_q;
		line_y_n     = line_y_q;
		end_x_n      = end_x_q;
		end_y_n      = end_y_q;
		err_n        = err_q;
		dx_n         = dx_q;
		dy_n         = dy_q;
		sx_neg_n     = sx_neg_q;
		sy_neg_n     = sy_neg_q;
		row_n        = row_q;
		col_n        = col_q;
		size_n       = size_q;
		color_n      = color_q;
		active_n     = active_q;
		do_move      = 1'b0;
		wv           = 1'b0;
		rej          = 1'b0;
		case (q_cmd.op)
			CMD_POINT: begin
				if (active_q) begin
					rej = 1'b1;
				end else begin
					line_x_n     = sx0;
					line_y_n     = sy0;
					end_x_n      = q_cmd.pen_x;
					end_y_n      = q_cmd.pen_y;
					dx_n         = diff_x[12] ? -diff_x : diff_x;
					dy_n         = diff_y[12] ? diff_y : -diff_y;
					sx_neg_n     = !(sx0 < q_cmd.pen_x);
					sy_neg_n     = !(sy0 < q_cmd.pen_y);
					err_n        = $signed({{2{dx_n[12]}}, dx_n}) + $signed({{2{dy_n[12]}}, dy_n});
					row_n        = 6'd0;
					col_n        = 6'd0;
					size_n       = q_cmd.size;
					color_n      = q_cmd.color;
					last_x_n     = q_cmd.pen_x;
					last_y_n     = q_cmd.pen_y;
					last_valid_n = 1'b1;
					active_n     = 1'b1;
				end
			end
			CMD_LIFT: begin
				last_valid_n = 1'b0;
			end
			CMD_TICK: begin
				if (active_q) begin
					if (half == 5'd0) begin
						do_move = 1'b1;
					end else begin
						wv    = in_disc && in_frame;
						col_n = col_inc;
						if (col_inc >= span) begin
							col_n = 6'd0;
							row_n = row_inc;
							if (row_inc >= span) begin
								row_n   = 6'd0;
								do_move = 1'b1;
							end
						end
					end
				end
			end
			default: begin
			end
		endcase
		if (do_move) begin
			if (at_end) begin
				active_n = 1'b0;
			end else begin
				if (step_x) begin
					line_x_n = line_x_q + (sx_neg_q ? 12'hFFF : 12'h001);
				end
				if (step_y) begin
					line_y_n = line_y_q + (sy_neg_q ? 12'hFFF : 12'h001);
				end
				err_n = err_q
					+ (step_x ? $signed({{2{dy_q[12]}}, dy_q}) : 15'sd0)
					+ (step_y ? $signed({{2{dx_q[12]}}, dx_q}) : 15'sd0);
			end
		end
	end

	assign s2_ok    = !s2_v_q || !out_stall;
	assign s1_ready = !s1_v_q || s2_ok;
	assign q_stall  = !s1_ready;
	assign take     = q_valid && s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_valid_q <= 1'b0;
			last_x_q     <= '0;
			last_y_q     <= '0;
			line_x_q     <= '0;
			line_y_q     <= '0;
			end_x_q      <= '0;
			end_y_q      <= '0;
			err_q        <= '0;
			dx_q         <= '0;
			dy_q         <= '0;
			sx_neg_q     <= 1'b0;
			sy_neg_q     <= 1'b0;
			row_q        <= '0;
			col_q        <= '0;
			size_q       <= '0;
			color_q      <= '0;
			active_q     <= 1'b0;
			s1_v_q       <= 1'b0;
			s2_v_q       <= 1'b0;
		end else begin
			if (take) begin
				last_valid_q <= last_valid_n;
				last_x_q     <= last_x_n;
				last_y_q     <= last_y_n;
				line_x_q     <= line_x_n;
				line_y_q     <= line_y_n;
				end_x_q      <= end_x_n;
				end_y_q      <= end_y_n;
				err_q        <= err_n;
				dx_q         <= dx_n;
				dy_q         <= dy_n;
				sx_neg_q     <= sx_neg_n;
				sy_neg_q     <= sy_neg_n;
				row_q        <= row_n;
				col_q        <= col_n;
				size_q       <= size_n;
				color_q      <= color_n;
				active_q     <= active_n;
			end
			if (s1_ready) begin
				s1_v_q <= take;
			end
			if (s2_ok) begin
				s2_v_q <= s1_v_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			wv_s1    <= wv;
			x_s1     <= wv ? xx[11:0] : 12'd0;
			y_s1     <= wv ? yy[11:0] : 12'd0;
			color_s1 <= wv ? color_q : 32'd0;
			busy_s1  <= active_n;
			rej_s1   <= rej;
		end
		if (s2_ok && s1_v_q) begin
			wv_s2    <= wv_s1;
			x_s2     <= x_s1[9:0];
			y_s2     <= y_s1[9:0];
			addr_s2  <= addr_full[25:0];
			color_s2 <= color_s1;
			busy_s2  <= busy_s1;
			rej_s2   <= rej_s1;
		end
	end

	assign addr_full = (row_pitch * y_s1) + {14'd0, x_s1, 2'b00};

	assign out_valid    = s2_v_q;
	assign write_valid  = wv_s2;
	assign pixel_x      = x_s2;
	assign pixel_y      = y_s2;
	assign byte_address = addr_s2;
	assign pixel_color  = color_s2;
	assign busy_res     = busy_s2;
	assign rejected     = rej_s2;

endmodule

`default_nettype wire

[rtl/core/thick_line_brush_rasterizer.sv]
`timescale 1ns / 1ps
`default_nettype none

// Pen-stroke rasterizer that draws a Bresenham line between successive pen points and stamps
// a disc brush at every line point; a brush size below two writes no pixels. Every transaction
// on the input channel gives exactly one transaction on the output channel, in order. One input
// transaction is accepted per clock cycle while the output is not stalled; the walk registers
// (line point, error term and disc offset counters) advance by one step per accepted step tick.
// A result is held first in the two-entry input queue, then in the first stage, which updates
// the walk and tests the disc offset, and then in the second, which forms the byte address with
// the row-pitch multiplier. The row pitch register must only be written while no transaction
// is in flight.
module thick_line_brush_rasterizer (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_write_en,
	input  wire logic [15:0]        cfg_write_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         kind,
	input  wire logic signed [11:0] pen_x,
	input  wire logic signed [11:0] pen_y,
	input  wire logic [5:0]         brush_size,
	input  wire logic [31:0]        brush_color,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    write_valid,
	output logic [9:0]              pixel_x,
	output logic [9:0]              pixel_y,
	output logic [25:0]             byte_address,
	output logic [31:0]             pixel_color,
	output logic                    busy_res,
	output logic                    rejected
);
	import tlbr_pkg::*;

	logic [15:0] row_pitch_q;
	logic        q_valid;
	logic        q_stall;
	cmd_t        q_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_pitch_q <= ROW_PITCH_RESET;
		end else if (cfg_write_en) begin
			row_pitch_q <= cfg_write_data;
		end
	end

	tlbr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.pen_x       (pen_x),
		.pen_y       (pen_y),
		.brush_size  (brush_size),
		.brush_color (brush_color),
		.q_valid     (q_valid),
		.q_cmd       (q_cmd),
		.q_stall     (q_stall)
	);

	tlbr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_cmd        (q_cmd),
		.q_stall      (q_stall),
		.row_pitch    (row_pitch_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.write_valid  (write_valid),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.byte_address (byte_address),
		.pixel_color  (pixel_color),
		.busy_res     (busy_res),
		.rejected     (rejected)
	);

endmodule

`default_nettype wire

[rtl/core/tlbr_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module tlbr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        write_valid,
	input wire logic [9:0]  pixel_x,
	input wire logic [9:0]  pixel_y,
	input wire logic [25:0] byte_address,
	input wire logic [31:0] pixel_color,
	input wire logic        busy_res,
	input wire logic        rejected
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid
			&& $stable({write_valid, pixel_x, pixel_y, byte_address,
				pixel_color, busy_res, rejected}))
		else $error("Output transaction changed while stalled.");

	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_valid |-> pixel_x == 10'd0 && pixel_y == 10'd0
			&& byte_address == 26'd0 && pixel_color == 32'd0)
		else $error("Pixel fields are not zero without a write.");

	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected |-> busy_res && !write_valid)
		else $error("Rejected point reported while idle or with a write.");

endmodule

bind thick_line_brush_rasterizer tlbr_checker u_tlbr_checker (.*);

`default_nettype wire

[sim/tb_thick_line_brush_rasterizer.sv]
`timescale 1ns / 1ps

module tb_thick_line_brush_rasterizer;
	import tlbr_pkg::*;

	typedef struct packed {
		logic        write_valid;
		logic [9:0]  pixel_x;
		logic [9:0]  pixel_y;
		logic [25:0] byte_address;
		logic [31:0] pixel_color;
		logic        busy_res;
		logic        rejected;
	} pixel_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write_en = 1'b0;
	logic [15:0] cfg_write_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] kind = CMD_TICK;
	logic signed [11:0] pen_x = '0;
	logic signed [11:0] pen_y = '0;
	logic [5:0] brush_size = '0;
	logic [31:0] brush_color = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic write_valid;
	logic [9:0] pixel_x;
	logic [9:0] pixel_y;
	logic [25:0] byte_address;
	logic [31:0] pixel_color;
	logic busy_res;
	logic rejected;

	thick_line_brush_rasterizer u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.kind           (kind),
		.pen_x          (pen_x),
		.pen_y          (pen_y),
		.brush_size     (brush_size),
		.brush_color    (brush_color),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.write_valid    (write_valid),
		.pixel_x        (pixel_x),
		.pixel_y        (pixel_y),
		.byte_address   (byte_address),
		.pixel_color    (pixel_color),
		.busy_res       (busy_res),
		.rejected       (rejected)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	pixel_result_t pixel_results_due[$];
	int errors = 0;
	int items_sent = 0;
	int results_checked = 0;
	int pixel_writes = 0;
	int points_rejected = 0;
	int pitch_settings = 0;
	int out_hold = 0;
	bit calm = 1'b0;

	// Shadow copy of the rasterizer state.
	logic [15:0] pitch = ROW_PITCH_RESET;
	bit pen_down = 1'b0;
	bit drawing = 1'b0;
	int last_px = 0, last_py = 0;
	int walk_x = 0, walk_y = 0, goal_x = 0, goal_y = 0;
	int bres_err = 0, run_dx = 0, run_dy = 0, dir_x = 0, dir_y = 0;
	int disc_row = 0, disc_col = 0;
	int stroke_size = 0;
	logic [31:0] stroke_color = '0;

	function automatic void advance_walk();
		int twice;
		if (walk_x == goal_x && walk_y == goal_y) begin
			drawing = 1'b0;
			return;
		end
		twice = 2 * bres_err;
		if (twice >= run_dy) begin
			bres_err += run_dy;
			walk_x += dir_x;
		end
		if (twice <= run_dx) begin
			bres_err += run_dx;
			walk_y += dir_y;
		end
	endfunction

	function automatic pixel_result_t rasterize_step(cmd_op_t op, logic signed [11:0] x,
			logic signed [11:0] y, logic [5:0] sz, logic [31:0] c);
		pixel_result_t res;
		int half, oi, oj, px, py, ox, oy;
		logic [31:0] addr_full;
		res = '0;
		case (op)
		CMD_POINT: begin
			if (drawing) begin
				res.rejected = 1'b1;
			end else begin
				ox = pen_down ? last_px : int'(x);
				oy = pen_down ? last_py : int'(y);
				goal_x = int'(x);
				goal_y = int'(y);
				walk_x = ox;
				walk_y = oy;
				run_dx = (goal_x > ox) ? goal_x - ox : ox - goal_x;
				run_dy = (goal_y > oy) ? oy - goal_y : goal_y - oy;
				dir_x = (ox < goal_x) ? 1 : -1;
				dir_y = (oy < goal_y) ? 1 : -1;
				bres_err = run_dx + run_dy;
				disc_row = 0;
				disc_col = 0;
				stroke_size = int'(sz);
				stroke_color = c;
				last_px = goal_x;
				last_py = goal_y;
				pen_down = 1'b1;
				drawing = 1'b1;
			end
		end
		CMD_LIFT: pen_down = 1'b0;
		CMD_TICK: begin
			if (drawing) begin
				half = stroke_size / 2;
				if (half == 0) begin
					advance_walk();
				end else begin
					oi = disc_row - half;
					oj = disc_col - half;
					if (4 * (oi * oi + oj * oj) + 2 <= stroke_size * stroke_size) begin
						px = walk_x + oj;
						py = walk_y + oi;
						if (px >= 0 && px < FRAME_WIDTH && py >= 0 && py < FRAME_HEIGHT) begin
							addr_full = 32'(pitch) * 32'(py) + 32'(4 * px);
							res.write_valid = 1'b1;
							res.pixel_x = 10'(px);
							res.pixel_y = 10'(py);
							res.byte_address = addr_full[25:0];
							res.pixel_color = stroke_color;
						end
					end
					disc_col++;
					if (disc_col >= 2 * half) begin
						disc_col = 0;
						disc_row++;
						if (disc_row >= 2 * half) begin
							disc_row = 0;
							advance_walk();
						end
					end
				end
			end
		end
		default: ;
		endcase
		res.busy_res = drawing;
		return res;
	endfunction

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		pixel_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pixel_results_due.size() == 0) begin
				errors++;
				$display("%0t: result transaction with nothing expected", $time);
			end else begin
				want = pixel_results_due.pop_front();
				compare_field("write_valid", 32'(want.write_valid), 32'(write_valid));
				compare_field("pixel_x", 32'(want.pixel_x), 32'(pixel_x));
				compare_field("pixel_y", 32'(want.pixel_y), 32'(pixel_y));
				compare_field("byte_address", 32'(want.byte_address), 32'(byte_address));
				compare_field("pixel_color", want.pixel_color, pixel_color);
				compare_field("busy_res", 32'(want.busy_res), 32'(busy_res));
				compare_field("rejected", 32'(want.rejected), 32'(rejected));
				results_checked++;
				if (want.write_valid)
					pixel_writes++;
				if (want.rejected)
					points_rejected++;
			end
			out_hold = calm ? 0 : $urandom_range(0, 4);
		end
		if (out_hold > 0) begin
			out_stall <= 1'b1;
			out_hold--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic send_item(cmd_op_t op, logic signed [11:0] x, logic signed [11:0] y,
			logic [5:0] sz, logic [31:0] c);
		int gap;
		pixel_result_t due;
		gap = calm ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= op;
		pen_x <= x;
		pen_y <= y;
		brush_size <= sz;
		brush_color <= c;
		do @(posedge clk); while (in_stall);
		due = rasterize_step(op, x, y, sz, c);
		pixel_results_due.insert(pixel_results_due.size(), due);
		items_sent++;
	endtask

	task automatic send_filler(cmd_op_t op);
		send_item(op, 12'($urandom), 12'($urandom), 6'($urandom), $urandom);
	endtask

	task automatic draw_out();
		while (drawing)
			send_filler(CMD_TICK);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pixel_results_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_pitch(logic [15:0] value);
		wait_idle();
		cfg_write_en <= 1'b1;
		cfg_write_data <= value;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		pitch = value;
		pitch_settings++;
	endtask

	task automatic test_idle_inputs();
		send_filler(CMD_TICK);
		send_filler(CMD_NOP);
		send_filler(CMD_LIFT);
		send_filler(CMD_TICK);
	endtask

	task automatic test_single_discs();
		send_item(CMD_POINT, 12'sd0, 12'sd0, 6'd7, 32'hFFFF_FFFF);
		draw_out();
		send_filler(CMD_LIFT);
		send_item(CMD_POINT, 12'sd1023, 12'sd1023, 6'd8, 32'h0000_0000);
		draw_out();
		send_filler(CMD_LIFT);
	endtask

	task automatic test_thin_lines();
		set_pitch(16'h0000);
		send_item(CMD_POINT, 12'sd10, 12'sd10, 6'd0, $urandom);
		draw_out();
		send_item(CMD_POINT, 12'sd30, 12'sd17, 6'd1, $urandom);
		draw_out();
		send_item(CMD_POINT, 12'sd25, 12'sd40, 6'd0, $urandom);
		draw_out();
		send_item(CMD_POINT, 12'sd5, 12'sd5, 6'd1, $urandom);
		draw_out();
		send_item(CMD_POINT, 12'sd5, 12'sd5, 6'd2, $urandom);
		draw_out();
		send_filler(CMD_LIFT);
	endtask

	task automatic test_busy_reject();
		set_pitch(16'd1000);
		send_item(CMD_POINT, 12'sd100, 12'sd100, 6'd4, $urandom);
		send_filler(CMD_TICK);
		send_item(CMD_POINT, 12'sd200, 12'sd200, 6'd5, $urandom);
		send_item(CMD_POINT, 12'sd104, 12'sd97, 6'd4, $urandom);
		draw_out();
		send_item(CMD_POINT, 12'sd112, 12'sd103, 6'd3, $urandom);
		send_filler(CMD_TICK);
		send_filler(CMD_LIFT);
		send_filler(CMD_NOP);
		draw_out();
		send_item(CMD_POINT, 12'sd50, 12'sd50, 6'd2, $urandom);
		draw_out();
		send_filler(CMD_LIFT);
	endtask

	task automatic test_large_brushes();
		set_pitch(16'hFFFF);
		calm = 1'b1;
		send_item(CMD_POINT, 12'sd1015, 12'sd8, 6'd22, $urandom);
		draw_out();
		send_filler(CMD_LIFT);
		send_item(CMD_POINT, -12'sd5, 12'sd1020, 6'd15, $urandom);
		draw_out();
		send_filler(CMD_LIFT);
		calm = 1'b0;
	endtask

	task automatic test_long_line();
		set_pitch(16'($urandom));
		calm = 1'b1;
		send_item(CMD_POINT, 12'h800, 12'sd2047, 6'd0, $urandom);
		draw_out();
		send_item(CMD_POINT, -12'sd1920, 12'sd1990, 6'd1, $urandom);
		draw_out();
		send_filler(CMD_LIFT);
		calm = 1'b0;
	endtask

	function automatic int pick_coord();
		case ($urandom_range(0, 2))
		0: return $urandom_range(0, 1023);
		1: return $urandom_range(0, 1) ? int'($urandom_range(0, 12)) - 6
			: 1018 + int'($urandom_range(0, 11));
		default: return int'($urandom_range(0, 4095)) - 2048;
		endcase
	endfunction

	function automatic int pick_size();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 45)
			return $urandom_range(0, 3);
		else if (roll < 85)
			return $urandom_range(4, 7);
		else
			return $urandom_range(8, 14);
	endfunction

	function automatic int nudge(int base, int span);
		int v;
		v = base + int'($urandom_range(0, 2 * span)) - span;
		if (v < -2048)
			v = -2048;
		if (v > 2047)
			v = 2047;
		return v;
	endfunction

	task automatic test_random_strokes();
		int goal, choice, roll, nx, ny, sz, span;
		goal = items_sent + 600;
		while (items_sent < goal) begin
			calm = ($urandom_range(0, 5) == 0);
			choice = $urandom_range(0, 99);
			if (choice < 6) begin
				send_filler(CMD_LIFT);
			end else if (choice < 10) begin
				send_filler($urandom_range(0, 1) ? CMD_NOP : CMD_TICK);
			end else if (choice < 12) begin
				set_pitch(16'($urandom));
			end else begin
				sz = pick_size();
				span = (sz < 4) ? 8 : 3;
				if (pen_down) begin
					nx = nudge(last_px, span);
					ny = nudge(last_py, span);
				end else begin
					nx = pick_coord();
					ny = pick_coord();
				end
				send_item(CMD_POINT, 12'(nx), 12'(ny), 6'(sz), $urandom);
				while (drawing) begin
					roll = $urandom_range(0, 99);
					if (roll < 3)
						send_filler(CMD_POINT);
					else if (roll < 5)
						send_filler(CMD_LIFT);
					else if (roll < 6)
						send_filler(CMD_NOP);
					else
						send_filler(CMD_TICK);
				end
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_inputs();
		test_single_discs();
		test_thin_lines();
		test_busy_reject();
		test_large_brushes();
		test_long_line();
		set_pitch(ROW_PITCH_RESET);
		test_random_strokes();
		wait_idle();
		repeat (8) @(posedge clk);
		$display("Run covered %0d input transactions and %0d checked results (%0d pixel writes,",
			items_sent, results_checked, pixel_writes);
		$display("%0d rejected points) across %0d row pitch settings.",
			points_rejected, pitch_settings);
		if (errors == 0 && pixel_results_due.size() == 0) begin
			$display("thick_line_brush_rasterizer regression: pass");
		end else begin
			$display("thick_line_brush_rasterizer regression: fail");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Run timed out with %0d results outstanding.", pixel_results_due.size());
		$display("thick_line_brush_rasterizer regression: fail");
		$finish;
	end

endmodule
